FILE: rtl/event_fifo_with_type_counters_defines.svh
// Assertion macros shared by the event queue RTL.
// Each macro expects clk and rst_n to be visible at the place of use.
`ifndef EVENT_FIFO_WITH_TYPE_COUNTERS_DEFINES_SVH
`define EVENT_FIFO_WITH_TYPE_COUNTERS_DEFINES_SVH

// Same-cycle implication.
`define EFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/efc_pkg.sv
package efc_pkg;

  // Queue and counter geometry
  localparam int DEPTH     = 32;
  localparam int NUM_TYPES = 16;
  localparam int SLOT_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_AW    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

  // Field widths
  localparam int OP_W    = 2;
  localparam int TYPE_W  = 8;
  localparam int AUX_W   = 32;
  localparam int STAMP_W = 64;
  localparam int CNT_W   = 32;
  localparam int ENTRY_W = TYPE_W + AUX_W + STAMP_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_COUNT = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // input transaction taken this cycle
    logic finish;  // retire the item into the output register
  } dp_cmd_t;

endpackage

FILE: rtl/efc_ram.sv
module efc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/efc_ctrl.sv
module efc_ctrl
  import efc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

`include "event_fifo_with_type_counters_defines.svh"

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    out_free   = !out_valid_r || out_ready;
    in_ready   = 1'b0;
    cmd        = '0;
    state_nxt  = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // memory read data is ready; retire once the output slot is free
        cmd.finish = out_free;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  `EFC_ASSERT_NXT(a_accept_exec, cmd.accept, state_r == S_EXEC, "accepted item did not start")
  `EFC_ASSERT_IMP(a_no_overwrite, cmd.finish, !out_valid_r || out_ready, "result overwritten")
  `EFC_ASSERT_NXT(a_result_shown, cmd.finish, out_valid_r, "retired result not presented")

endmodule

FILE: rtl/efc_dp.sv
module efc_dp
  import efc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [TYPE_W-1:0]  in_event_type,
  input  logic [AUX_W-1:0]   in_aux_word,
  input  logic [STAMP_W-1:0] in_now_us,
  output logic               out_got_entry,
  output logic [TYPE_W-1:0]  out_type,
  output logic [AUX_W-1:0]   out_aux,
  output logic [STAMP_W-1:0] out_stamp,
  output logic [CNT_W-1:0]   out_type_count,
  output logic               out_fault
);

`include "event_fifo_with_type_counters_defines.svh"

  // Latched transaction
  op_t                op_r;
  logic [TYPE_W-1:0]  type_r;
  logic [AUX_W-1:0]   aux_r;
  logic [STAMP_W-1:0] now_r;

  // Queue control state
  logic [SLOT_W-1:0]  rd_slot_r, rd_slot_nxt;
  logic [SLOT_W-1:0]  wr_slot_r, wr_slot_nxt;
  logic               fault_r, fault_nxt;
  logic               cnt_vld_r [NUM_TYPES];

  // Result register
  logic               got_r;
  logic [TYPE_W-1:0]  otype_r;
  logic [AUX_W-1:0]   oaux_r;
  logic [STAMP_W-1:0] ostamp_r;
  logic [CNT_W-1:0]   ocnt_r;
  logic               ofault_r;

  logic [ENTRY_W-1:0] entry_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   cnt_cur;
  logic [CNT_AW-1:0]  cnt_idx;
  logic               type_ok;
  logic               cnt_hit;
  logic               full, empty;
  logic               do_push, push_fault, do_pop, do_cnt;
  logic [SLOT_W-1:0]  wr_inc, rd_inc;

  // Entry store: one slot per queue position
  efc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (cmd.finish && do_push),
    .waddr (wr_slot_r),
    .wdata ({type_r, aux_r, now_r}),
    .re    (cmd.accept),
    .raddr (rd_slot_r),
    .rdata (entry_q)
  );

  // Per-type push counters; a counter never written reads as zero
  efc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_TYPES)
  ) u_count_ram (
    .clk   (clk),
    .we    (cmd.finish && do_push && type_ok),
    .waddr (cnt_idx),
    .wdata (cnt_cur + CNT_W'(1)),
    .re    (cmd.accept),
    .raddr (in_event_type[CNT_AW-1:0]),
    .rdata (cnt_q)
  );

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= op_t'(in_operation);
      type_r <= in_event_type;
      aux_r  <= in_aux_word;
      now_r  <= in_now_us;
    end
  end

  // Slot arithmetic and item decode
  always_comb begin
    cnt_idx     = type_r[CNT_AW-1:0];
    type_ok     = {1'b0, type_r} < (TYPE_W + 1)'(NUM_TYPES);
    cnt_hit     = type_ok && cnt_vld_r[cnt_idx];
    cnt_cur     = cnt_hit ? cnt_q : '0;
    wr_inc      = (wr_slot_r == SLOT_W'(DEPTH - 1)) ? '0 : wr_slot_r + 1'b1;
    rd_inc      = (rd_slot_r == SLOT_W'(DEPTH - 1)) ? '0 : rd_slot_r + 1'b1;
    full        = wr_inc == rd_slot_r;
    empty       = rd_slot_r == wr_slot_r;
    do_push     = !fault_r && (op_r == OP_PUSH) && !full;
    push_fault  = !fault_r && (op_r == OP_PUSH) && full;
    do_pop      = !fault_r && (op_r == OP_POP) && !empty;
    do_cnt      = !fault_r && (op_r == OP_COUNT) && type_ok;
    wr_slot_nxt = wr_slot_r;
    rd_slot_nxt = rd_slot_r;
    fault_nxt   = fault_r;
    if (cmd.finish) begin
      if (do_push) begin
        wr_slot_nxt = wr_inc;
      end
      if (do_pop) begin
        rd_slot_nxt = rd_inc;
      end
      if (push_fault) begin
        fault_nxt = 1'b1;
      end
    end
  end

  // Queue pointers, sticky fault and counter valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_slot_r <= '0;
      wr_slot_r <= '0;
      fault_r   <= 1'b0;
      for (int i = 0; i < NUM_TYPES; i++) begin
        cnt_vld_r[i] <= 1'b0;
      end
    end else begin
      rd_slot_r <= rd_slot_nxt;
      wr_slot_r <= wr_slot_nxt;
      fault_r   <= fault_nxt;
      if (cmd.finish && do_push && type_ok) begin
        cnt_vld_r[cnt_idx] <= 1'b1;
      end
    end
  end

  // Result register, loaded when the item retires
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      got_r    <= do_pop;
      otype_r  <= do_pop ? entry_q[ENTRY_W-1 -: TYPE_W] : '0;
      oaux_r   <= do_pop ? entry_q[STAMP_W +: AUX_W] : '0;
      ostamp_r <= do_pop ? entry_q[STAMP_W-1:0] : '0;
      ocnt_r   <= do_cnt ? cnt_cur : '0;
      ofault_r <= fault_nxt;
    end
  end

  assign out_got_entry  = got_r;
  assign out_type       = otype_r;
  assign out_aux        = oaux_r;
  assign out_stamp      = ostamp_r;
  assign out_type_count = ocnt_r;
  assign out_fault      = ofault_r;

  `EFC_ASSERT_NXT(a_fault_sticky, fault_r, fault_r, "fault flag cleared without reset")

endmodule

FILE: rtl/event_fifo_with_type_counters.sv
// Event queue with per-type push counters. Each transaction is a push, a pop,
// a count query or a no-op and yields exactly one result. The queue holds DEPTH-1
// entries; a push into a full queue raises a sticky fault, after which every
// transaction returns only fault = 1 until reset. On acceptance the entry
// and counter memories are read; once the output register is free the item
// retires into it (counter update and pointer moves included). A new item is
// taken only after the last one retires. The output register lets the next
// item enter while a result waits; the item then holds until that result is
// taken.
module event_fifo_with_type_counters
  import efc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [TYPE_W-1:0]  in_event_type,
  input  logic [AUX_W-1:0]   in_aux_word,
  input  logic [STAMP_W-1:0] in_now_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_got_entry,
  output logic [TYPE_W-1:0]  out_type,
  output logic [AUX_W-1:0]   out_aux,
  output logic [STAMP_W-1:0] out_stamp,
  output logic [CNT_W-1:0]   out_type_count,
  output logic               out_fault
);

  dp_cmd_t cmd;

  efc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  efc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_operation   (in_operation),
    .in_event_type  (in_event_type),
    .in_aux_word    (in_aux_word),
    .in_now_us      (in_now_us),
    .out_got_entry  (out_got_entry),
    .out_type       (out_type),
    .out_aux        (out_aux),
    .out_stamp      (out_stamp),
    .out_type_count (out_type_count),
    .out_fault      (out_fault)
  );

endmodule
